[src/assert_macros.svh]
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error(msg);

`endif

[src/hrhp_pkg.sv]
// ----------------------------------------------------------------------------
// hrhp_pkg
// Types, constants and helpers for the request header parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_request;
  } in_word_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] token_class;
    logic [1:0] status;
    logic [7:0] version_major;
    logic [7:0] version_minor;
    logic       conn_persist;
  } out_word_t;

  // Byte classification produced by the front end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_request;
    logic       is_ws;
    logic       is_digit;
    logic       is_cr;
    logic       is_lf;
  } cls_word_t;

  typedef enum logic [17:0] {
    ST_BEFORE_METHOD = 18'h00001,
    ST_METHOD        = 18'h00002,
    ST_BEFORE_URI    = 18'h00004,
    ST_URI           = 18'h00008,
    ST_BEFORE_HTTP   = 18'h00010,
    ST_H             = 18'h00020,
    ST_HT            = 18'h00040,
    ST_HTT           = 18'h00080,
    ST_HTTP          = 18'h00100,
    ST_SLASH         = 18'h00200,
    ST_MAJOR         = 18'h00400,
    ST_DOT           = 18'h00800,
    ST_MINOR         = 18'h01000,
    ST_BEFORE_HEADER = 18'h02000,
    ST_KEY           = 18'h04000,
    ST_COLON         = 18'h08000,
    ST_VALUE         = 18'h10000,
    ST_FINISHED      = 18'h20000
  } parse_state_e;

  typedef enum logic [1:0] {
    PART_PATH     = 2'd0,
    PART_QUERY    = 2'd1,
    PART_FRAGMENT = 2'd2
  } uri_part_e;

  localparam logic [2:0] CLS_NONE     = 3'd0;
  localparam logic [2:0] CLS_METHOD   = 3'd1;
  localparam logic [2:0] CLS_PATH     = 3'd2;
  localparam logic [2:0] CLS_QUERY    = 3'd3;
  localparam logic [2:0] CLS_FRAGMENT = 3'd4;
  localparam logic [2:0] CLS_KEY      = 3'd5;
  localparam logic [2:0] CLS_VALUE    = 3'd6;
  localparam logic [2:0] CLS_LINE_END = 3'd7;

  localparam logic [1:0] STATUS_PENDING  = 2'd0;
  localparam logic [1:0] STATUS_COMPLETE = 2'd1;
  localparam logic [1:0] STATUS_INVALID  = 2'd2;

  localparam logic [2:0] METHOD_LEN  = 3'd3;
  localparam logic [2:0] METHOD_MISS = 3'd7;
  localparam logic [3:0] TEXT_LEN    = 4'd10;
  localparam logic [3:0] TEXT_MISS   = 4'd15;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;

  function automatic logic [7:0] get_char(input logic [2:0] pos);
    case (pos)
      3'd0:    get_char = 8'h47; // G
      3'd1:    get_char = 8'h45; // E
      default: get_char = 8'h54; // T
    endcase
  endfunction

  function automatic logic [7:0] conn_char(input logic [3:0] pos);
    case (pos)
      4'd0:    conn_char = 8'h43; // C
      4'd1:    conn_char = 8'h6f; // o
      4'd2:    conn_char = 8'h6e; // n
      4'd3:    conn_char = 8'h6e;
      4'd4:    conn_char = 8'h65; // e
      4'd5:    conn_char = 8'h63; // c
      4'd6:    conn_char = 8'h74; // t
      4'd7:    conn_char = 8'h69; // i
      4'd8:    conn_char = 8'h6f;
      default: conn_char = 8'h6e;
    endcase
  endfunction

  function automatic logic [7:0] ka_char(input logic [3:0] pos);
    case (pos)
      4'd0:    ka_char = 8'h4b; // K
      4'd1:    ka_char = 8'h65; // e
      4'd2:    ka_char = 8'h65;
      4'd3:    ka_char = 8'h70; // p
      4'd4:    ka_char = 8'h2d; // -
      4'd5:    ka_char = 8'h41; // A
      4'd6:    ka_char = 8'h6c; // l
      4'd7:    ka_char = 8'h69; // i
      4'd8:    ka_char = 8'h76; // v
      default: ka_char = 8'h65; // e
    endcase
  endfunction

  // Accumulate one decimal digit, saturating at 255.
  function automatic logic [7:0] sat_digit(input logic [7:0] acc, input logic [7:0] c);
    logic [11:0] v;
    v = {acc, 3'b000} + {3'b000, acc, 1'b0} + {4'd0, c - 8'h30};
    sat_digit = (v > 12'd255) ? 8'hff : v[7:0];
  endfunction

endpackage

[src/hrhp_front.sv]
// ----------------------------------------------------------------------------
// hrhp_front
// Accepts request bytes, classifies them and queues them for the parser.
// ----------------------------------------------------------------------------
module hrhp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  hrhp_pkg::in_word_t in_word_i,
  output logic               q_valid_o,
  input  logic               q_take_i,
  output hrhp_pkg::cls_word_t q_word_o
);
  import hrhp_pkg::*;
  `include "assert_macros.svh"

  cls_word_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]     cnt_q, cnt_d;
  cls_word_t           cls;
  logic                do_push, do_pop;
  logic [7:0]          c;

  // Classify the incoming byte
  always_comb begin
    c = in_word_i.data_byte;
    cls.data_byte   = c;
    cls.new_request = in_word_i.new_request;
    cls.is_ws       = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    cls.is_digit    = (c >= 8'h30) && (c <= 8'h39);
    cls.is_cr       = (c == 8'h0d);
    cls.is_lf       = (c == 8'h0a);
  end

  assign full_o    = (cnt_q == QDEPTH[QPTR_W:0]);
  assign q_valid_o = (cnt_q != '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = q_take_i && q_valid_o;
  assign q_word_o  = mem_q[rd_q];

  // Advance pointers and count
  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + {{QPTR_W{1'b0}}, do_push} - {{QPTR_W{1'b0}}, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store classified word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cls;
    end
  end

  `ASSERT_PROP(a_cnt_range, clk_i, rst_ni, cnt_q <= QDEPTH[QPTR_W:0], "queue overflow")
  `ASSERT_NEXT(a_push_grows, clk_i, rst_ni, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1,
               "count did not grow")
  `ASSERT_NEXT(a_pop_shrinks, clk_i, rst_ni, do_pop && !do_push, cnt_q == $past(cnt_q) - 1'b1,
               "count did not shrink")
endmodule

[src/hrhp_back.sv]
// ----------------------------------------------------------------------------
// hrhp_back
// Parser state machine; writes one result word per byte into an output queue.
// ----------------------------------------------------------------------------
module hrhp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_take_o,
  input  hrhp_pkg::cls_word_t q_word_i,
  output logic                empty_o,
  input  logic                pop_i,
  output hrhp_pkg::out_word_t out_word_o
);
  import hrhp_pkg::*;
  `include "assert_macros.svh"

  parse_state_e st_q, st_d, st_r;
  uri_part_e    part_q, part_d, part_r;
  logic [7:0]   maj_q, maj_d, maj_r, min_q, min_d, min_r;
  logic [2:0]   mpos_q, mpos_d, mpos_r;
  logic [3:0]   kpos_q, kpos_d, kpos_r, vpos_q, vpos_d, vpos_r;
  logic         cseen_q, cseen_d, cseen_r, cka_q, cka_d, cka_r;
  logic         fail_q, fail_d, fail_r;
  logic [2:0]   cls;
  logic         fail;
  logic [7:0]   c;
  out_word_t    res;

  out_word_t         oq_q [QDEPTH];
  logic [QPTR_W-1:0] owr_q, ord_q;
  logic [QPTR_W:0]   ocnt_q;
  logic              ofull, opop;

  assign ofull    = (ocnt_q == QDEPTH[QPTR_W:0]);
  assign q_take_o = q_valid_i && !ofull;
  assign empty_o  = (ocnt_q == '0);
  assign opop     = pop_i && !empty_o;
  assign out_word_o = oq_q[ord_q];
  assign c        = q_word_i.data_byte;

  // Apply new-request reset ahead of the byte
  always_comb begin
    st_r = st_q; part_r = part_q; maj_r = maj_q; min_r = min_q;
    mpos_r = mpos_q; kpos_r = kpos_q; vpos_r = vpos_q;
    cseen_r = cseen_q; cka_r = cka_q; fail_r = fail_q;
    if (q_word_i.new_request) begin
      st_r = ST_BEFORE_METHOD; part_r = PART_PATH; maj_r = '0; min_r = '0;
      mpos_r = '0; kpos_r = '0; vpos_r = '0;
      cseen_r = 1'b0; cka_r = 1'b0; fail_r = 1'b0;
    end
  end

  // Parse one byte
  always_comb begin
    st_d = st_r; part_d = part_r; maj_d = maj_r; min_d = min_r;
    mpos_d = mpos_r; kpos_d = kpos_r; vpos_d = vpos_r;
    cseen_d = cseen_r; cka_d = cka_r; fail_d = fail_r;
    cls  = CLS_NONE;
    fail = 1'b0;
    if (!fail_r) begin
      unique case (st_r)
        ST_BEFORE_METHOD: begin
          if (!q_word_i.is_cr && !q_word_i.is_lf) begin
            st_d   = ST_METHOD;
            mpos_d = (c == get_char(3'd0)) ? 3'd1 : METHOD_MISS;
            cls    = CLS_METHOD;
          end
        end
        ST_METHOD: begin
          if (q_word_i.is_ws) begin
            st_d = ST_BEFORE_URI;
          end else begin
            mpos_d = (mpos_r < METHOD_LEN && c == get_char(mpos_r)) ? mpos_r + 3'd1
                                                                     : METHOD_MISS;
            cls = CLS_METHOD;
          end
        end
        ST_BEFORE_URI: begin
          if (!q_word_i.is_ws) begin
            if (c == 8'h2f) begin
              st_d = ST_URI; part_d = PART_PATH; cls = CLS_PATH;
            end else begin
              fail = 1'b1;
            end
          end
        end
        ST_URI: begin
          if (q_word_i.is_ws) begin
            st_d = ST_BEFORE_HTTP;
          end else if (part_r == PART_PATH) begin
            if (c == 8'h3f) part_d = PART_QUERY;
            else if (c == 8'h23) part_d = PART_FRAGMENT;
            else cls = CLS_PATH;
          end else if (part_r == PART_QUERY) begin
            if (c == 8'h23) part_d = PART_FRAGMENT;
            else cls = CLS_QUERY;
          end else begin
            cls = CLS_FRAGMENT;
          end
        end
        ST_BEFORE_HTTP: begin
          if (!q_word_i.is_ws) begin
            if (c == 8'h48) st_d = ST_H;
            else fail = 1'b1;
          end
        end
        ST_H: begin
          if (c == 8'h54) st_d = ST_HT; else fail = 1'b1;
        end
        ST_HT: begin
          if (c == 8'h54) st_d = ST_HTT; else fail = 1'b1;
        end
        ST_HTT: begin
          if (c == 8'h50) st_d = ST_HTTP; else fail = 1'b1;
        end
        ST_HTTP: begin
          if (c == 8'h2f) st_d = ST_SLASH; else fail = 1'b1;
        end
        ST_SLASH: begin
          if (q_word_i.is_digit) begin
            maj_d = c - 8'h30; st_d = ST_MAJOR;
          end else begin
            fail = 1'b1;
          end
        end
        ST_MAJOR: begin
          if (q_word_i.is_digit) maj_d = sat_digit(maj_r, c);
          else if (c == 8'h2e) st_d = ST_DOT;
          else fail = 1'b1;
        end
        ST_DOT: begin
          if (q_word_i.is_digit) begin
            min_d = c - 8'h30; st_d = ST_MINOR;
          end else begin
            fail = 1'b1;
          end
        end
        ST_MINOR: begin
          if (q_word_i.is_digit) begin
            min_d = sat_digit(min_r, c);
          end else if (q_word_i.is_cr) begin
            cls = CLS_LINE_END;
          end else if (q_word_i.is_lf) begin
            cls = CLS_LINE_END; st_d = ST_BEFORE_HEADER;
          end else begin
            fail = 1'b1;
          end
        end
        ST_BEFORE_HEADER: begin
          if (q_word_i.is_cr) begin
            cls = CLS_LINE_END;
          end else if (q_word_i.is_lf) begin
            cls  = CLS_LINE_END;
            st_d = ST_FINISHED;
            if (mpos_r != METHOD_LEN) fail = 1'b1;
          end else begin
            st_d   = ST_KEY;
            kpos_d = (c == conn_char(4'd0)) ? 4'd1 : TEXT_MISS;
            cls    = CLS_KEY;
          end
        end
        ST_KEY: begin
          if (c == 8'h3a) begin
            st_d = ST_COLON;
          end else if (q_word_i.is_cr || q_word_i.is_lf) begin
            fail = 1'b1;
          end else begin
            kpos_d = (kpos_r < TEXT_LEN && c == conn_char(kpos_r)) ? kpos_r + 4'd1
                                                                    : TEXT_MISS;
            cls = CLS_KEY;
          end
        end
        ST_COLON: begin
          if (!q_word_i.is_ws) begin
            st_d   = ST_VALUE;
            vpos_d = (c == ka_char(4'd0)) ? 4'd1 : TEXT_MISS;
            cls    = CLS_VALUE;
          end
        end
        ST_VALUE: begin
          if (q_word_i.is_cr) begin
            cls = CLS_LINE_END;
          end else if (q_word_i.is_lf) begin
            cls  = CLS_LINE_END;
            st_d = ST_BEFORE_HEADER;
            if (kpos_r == TEXT_LEN) begin
              if (cseen_r) begin
                fail = 1'b1;
              end else begin
                cseen_d = 1'b1;
                cka_d   = (vpos_r == TEXT_LEN);
              end
            end
          end else begin
            vpos_d = (vpos_r < TEXT_LEN && c == ka_char(vpos_r)) ? vpos_r + 4'd1
                                                                  : TEXT_MISS;
            cls = CLS_VALUE;
          end
        end
        ST_FINISHED: begin
          fail = 1'b1;
        end
        default: begin
          fail = 1'b1;
        end
      endcase
      if (fail) begin
        fail_d = 1'b1;
        cls    = CLS_NONE;
      end
    end
  end

  // Build the result word
  always_comb begin
    res.byte_out      = c;
    res.token_class   = cls;
    res.version_major = maj_d;
    res.version_minor = min_d;
    if (fail_d) begin
      res.status = STATUS_INVALID; res.conn_persist = 1'b0;
    end else if (st_d == ST_FINISHED) begin
      res.status = STATUS_COMPLETE;
      res.conn_persist = (maj_d == 8'd1 && min_d == 8'd0) ? (cseen_d && cka_d) : !cseen_d;
    end else begin
      res.status = STATUS_PENDING; res.conn_persist = 1'b0;
    end
  end

  // Hold parser state; advance on each taken byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_BEFORE_METHOD; part_q <= PART_PATH; maj_q <= '0; min_q <= '0;
      mpos_q <= '0; kpos_q <= '0; vpos_q <= '0;
      cseen_q <= 1'b0; cka_q <= 1'b0; fail_q <= 1'b0;
      owr_q <= '0; ord_q <= '0; ocnt_q <= '0;
    end else begin
      if (q_take_o) begin
        st_q <= st_d; part_q <= part_d; maj_q <= maj_d; min_q <= min_d;
        mpos_q <= mpos_d; kpos_q <= kpos_d; vpos_q <= vpos_d;
        cseen_q <= cseen_d; cka_q <= cka_d; fail_q <= fail_d;
        owr_q <= owr_q + 1'b1;
      end
      if (opop) ord_q <= ord_q + 1'b1;
      ocnt_q <= ocnt_q + {{QPTR_W{1'b0}}, q_take_o} - {{QPTR_W{1'b0}}, opop};
    end
  end

  // Store result word
  always_ff @(posedge clk_i) begin
    if (q_take_o) oq_q[owr_q] <= res;
  end

  `ASSERT_PROP(a_ocnt_range, clk_i, rst_ni, ocnt_q <= QDEPTH[QPTR_W:0], "result overflow")
  `ASSERT_NEXT(a_fail_sticky, clk_i, rst_ni, fail_q && !(q_take_o && q_word_i.new_request),
               fail_q, "invalid flag dropped")
  `ASSERT_NEXT(a_fail_freeze, clk_i, rst_ni, fail_q && !(q_take_o && q_word_i.new_request),
               $stable(st_q), "state moved while failed")
endmodule

[src/http_request_header_parser_top.sv]
// ----------------------------------------------------------------------------
// http_request_header_parser_top
// HTTP/1.x request header parser, one byte in and one result word out.
// ----------------------------------------------------------------------------
// Input channel: push with in_word_i; a word is taken when push is high
// and full is low. Set new_request on the first byte of each request.
// Result channel: while empty is low the oldest result word is on
// out_word_o; it is taken when pop is high. Each byte gives one result with
// its token class, parse status, version so far and keep-alive decision.
// A taken byte passes the input queue, then the parser, into the result queue.
// Throughput: one byte per cycle while pop keeps the result queue from filling;
// a two-word queue sits between the byte classifier and the parser, and a
// two-word queue holds results.
// Reset clears both queues and returns the parser to the start of a request.
// When pop stays low the result queue fills, the parser then stops taking
// bytes, the input queue fills and full rises; nothing is lost.
// ----------------------------------------------------------------------------
module http_request_header_parser_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  hrhp_pkg::in_word_t  in_word_i,
  output logic                empty,
  input  logic                pop,
  output hrhp_pkg::out_word_t out_word_o
);
  import hrhp_pkg::*;

  logic      q_valid, q_take;
  cls_word_t q_word;

  hrhp_front u_front (
    .clk_i, .rst_ni,
    .push_i    (push),
    .full_o    (full),
    .in_word_i (in_word_i),
    .q_valid_o (q_valid),
    .q_take_i  (q_take),
    .q_word_o  (q_word)
  );

  hrhp_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i  (q_valid),
    .q_take_o   (q_take),
    .q_word_i   (q_word),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_word_o (out_word_o)
  );
endmodule
